[rtl/assert_macros.svh]
// Assertion macros shared by the RTL files of the vertex set filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check prop at every rising edge of clk, held off while rst_n is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that cond never holds at a rising edge of clk outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

[rtl/mtvsf_pkg.sv]
// Package: widths, operation codes and index helpers of the vertex set filter.
`timescale 1ns / 1ps
`default_nettype none
package mtvsf_pkg;

    localparam int FIELD_W     = 18;
    localparam int VERTEX_BITS = 18;
    localparam int OP_W        = 2;
    localparam int WORD_W      = 32;
    localparam int BIT_SEL_W   = 5;
    localparam int ADDR_W      = VERTEX_BITS - BIT_SEL_W;
    localparam int DEPTH       = 1 << ADDR_W;
    localparam int EXT_W       = (VERTEX_BITS > FIELD_W) ? VERTEX_BITS : FIELD_W;
    localparam int NUM_LANES   = 3;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_TEST   = 2'd2;

    // One bitmap write, broadcast to every lane copy.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } wr_t;

    // One bitmap lookup for a single lane.
    typedef struct packed {
        logic               en;
        logic [FIELD_W-1:0] idx;
    } lookup_t;

    function automatic logic idx_in_range(input logic [FIELD_W-1:0] idx);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(idx);
        return (ext >> VERTEX_BITS) == '0;
    endfunction

    function automatic logic [ADDR_W-1:0] idx_word(input logic [FIELD_W-1:0] idx);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(idx);
        return ext[VERTEX_BITS-1:BIT_SEL_W];
    endfunction

    function automatic logic [BIT_SEL_W-1:0] idx_bit(input logic [FIELD_W-1:0] idx);
        return idx[BIT_SEL_W-1:0];
    endfunction

endpackage
`default_nettype wire

[rtl/mtvsf_ram.sv]
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mtvsf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[rtl/mtvsf_lane.sv]
// Lookup lane: one bitmap copy and the membership test of one corner.
`timescale 1ns / 1ps
`default_nettype none
module mtvsf_lane
    import mtvsf_pkg::*;
(
    input  wire logic    clk,
    input  wire lookup_t rd,
    input  wire wr_t     wr,
    output logic [WORD_W-1:0] word,
    output logic         hit
);

    logic                 in_range_reg;
    logic [BIT_SEL_W-1:0] bit_reg;

    mtvsf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd.en),
        .raddr (idx_word(rd.idx)),
        .rdata (word)
    );

    // Hold the bit position alongside the word read.
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            in_range_reg <= idx_in_range(rd.idx);
            bit_reg      <= idx_bit(rd.idx);
        end
    end

    assign hit = in_range_reg & word[bit_reg];

endmodule
`default_nettype wire

[rtl/mtvsf_merge.sv]
// Merge stage: combine the lane hits and hold a kept triangle for transfer.
`timescale 1ns / 1ps
`default_nettype none
module mtvsf_merge
    import mtvsf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 take,
    input  wire logic [NUM_LANES-1:0] hit,
    input  wire logic [FIELD_W-1:0]   corner_a,
    input  wire logic [FIELD_W-1:0]   corner_b,
    input  wire logic [FIELD_W-1:0]   corner_c,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output logic [FIELD_W-1:0]        kept_corner_a,
    output logic [FIELD_W-1:0]        kept_corner_b,
    output logic [FIELD_W-1:0]        kept_corner_c,
    output logic                      done
);

    `include "assert_macros.svh"

    logic               out_valid_reg;
    logic [FIELD_W-1:0] kept_a_reg;
    logic [FIELD_W-1:0] kept_b_reg;
    logic [FIELD_W-1:0] kept_c_reg;
    logic               hit_any;
    logic               slot_free;
    logic               load;

    assign hit_any   = |hit;
    assign slot_free = !out_valid_reg || out_ready;
    assign load      = take && hit_any && slot_free;
    assign done      = take && (!hit_any || slot_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kept_a_reg <= corner_a;
            kept_b_reg <= corner_b;
            kept_c_reg <= corner_c;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kept_corner_a = kept_a_reg;
    assign kept_corner_b = kept_b_reg;
    assign kept_corner_c = kept_c_reg;

    `ASSERT_CLK(a_load_into_free_slot, clk, rst_n, load |-> (!out_valid_reg || out_ready), "triangle loaded over a waiting one")
    `ASSERT_CLK(a_hit_done_means_load, clk, rst_n, (done && hit_any) |=> out_valid_reg, "kept triangle not presented")

endmodule
`default_nettype wire

[rtl/mesh_triangle_vertex_set_filter.sv]
// Top level: triangle filter against a vertex membership bitmap.
//
//   channel  direction  handshake              payload
//   -------  ---------  ---------------------  ------------------------------------------
//   in       input      in_valid / in_ready    operation, vertex_index, corner_a/b/c
//   out      output     out_valid / out_ready  kept_corner_a, kept_corner_b, kept_corner_c
//
// In a test item the three lanes read their bitmap copies in the transfer cycle
// and the merge stage ORs the registered hits in the MERGE state.
// An insert reads the word in lane 0, then writes it to all copies in the INSERT state.
// A clear runs a sweep of one bitmap word per cycle through the shared write port.
// After reset the same sweep runs before the first transfer.
// A kept triangle waiting on out_ready stalls only the next test that hits.
`timescale 1ns / 1ps
`default_nettype none
module mesh_triangle_vertex_set_filter
    import mtvsf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [OP_W-1:0]    operation,
    input  wire logic [FIELD_W-1:0] vertex_index,
    input  wire logic [FIELD_W-1:0] corner_a,
    input  wire logic [FIELD_W-1:0] corner_b,
    input  wire logic [FIELD_W-1:0] corner_c,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [FIELD_W-1:0]      kept_corner_a,
    output logic [FIELD_W-1:0]      kept_corner_b,
    output logic [FIELD_W-1:0]      kept_corner_c
);

    `include "assert_macros.svh"

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_MERGE  = 4'b0100,
        S_INSERT = 4'b1000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [ADDR_W-1:0]    clr_cnt_reg;
    logic [ADDR_W-1:0]    clr_cnt_next;
    logic                 ins_ok_reg;
    logic [ADDR_W-1:0]    ins_addr_reg;
    logic [BIT_SEL_W-1:0] ins_bit_reg;
    logic [FIELD_W-1:0]   corner_a_reg;
    logic [FIELD_W-1:0]   corner_b_reg;
    logic [FIELD_W-1:0]   corner_c_reg;

    logic                 accept;
    logic                 acc_test;
    logic                 acc_insert;
    lookup_t              lookup [NUM_LANES];
    wr_t                  wr;
    logic [WORD_W-1:0]    word   [NUM_LANES];
    logic [NUM_LANES-1:0] hit;
    logic                 take;
    logic                 done;

    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign acc_test   = accept && (operation == OP_TEST);
    assign acc_insert = accept && (operation == OP_INSERT);
    assign take       = (state_reg == S_MERGE);

    // Lane 0 also serves the read half of an insert.
    always_comb
    begin
        lookup[0].en  = acc_test || acc_insert;
        lookup[0].idx = (operation == OP_INSERT) ? vertex_index : corner_a;
        lookup[1].en  = acc_test;
        lookup[1].idx = corner_b;
        lookup[2].en  = acc_test;
        lookup[2].idx = corner_c;
    end

    // Sweep zeros while clearing, otherwise write back the insert word.
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            wr.en   = 1'b1;
            wr.addr = clr_cnt_reg;
            wr.data = '0;
        end
        else
        begin
            wr.en   = (state_reg == S_INSERT) && ins_ok_reg;
            wr.addr = ins_addr_reg;
            wr.data = word[0] | (WORD_W'(1) << ins_bit_reg);
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        mtvsf_lane u_lane (
            .clk  (clk),
            .rd   (lookup[g]),
            .wr   (wr),
            .word (word[g]),
            .hit  (hit[g])
        );
    end

    mtvsf_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .hit           (hit),
        .corner_a      (corner_a_reg),
        .corner_b      (corner_b_reg),
        .corner_c      (corner_c_reg),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .kept_corner_a (kept_corner_a),
        .kept_corner_b (kept_corner_b),
        .kept_corner_c (kept_corner_c),
        .done          (done)
    );

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (operation)
                        OP_CLEAR:
                        begin
                            state_next   = S_CLEAR;
                            clr_cnt_next = '0;
                        end
                        OP_INSERT: state_next = S_INSERT;
                        OP_TEST:   state_next = S_MERGE;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_MERGE:
            begin
                if (done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_INSERT: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Hold the item payload for the cycles after the transfer.
    always_ff @(posedge clk)
    begin
        if (acc_insert)
        begin
            ins_ok_reg   <= idx_in_range(vertex_index);
            ins_addr_reg <= idx_word(vertex_index);
            ins_bit_reg  <= idx_bit(vertex_index);
        end
        if (acc_test)
        begin
            corner_a_reg <= corner_a;
            corner_b_reg <= corner_b;
            corner_c_reg <= corner_c;
        end
    end

    `ASSERT_CLK(a_test_goes_merge, clk, rst_n, acc_test |=> (state_reg == S_MERGE), "test transfer did not reach merge")
    `ASSERT_CLK(a_clear_restarts_sweep, clk, rst_n, (accept && (operation == OP_CLEAR)) |=> ((state_reg == S_CLEAR) && (clr_cnt_reg == '0)), "clear did not restart sweep")
    `ASSERT_NEVER(a_no_write_in_merge, clk, rst_n, (state_reg == S_MERGE) && wr.en, "bitmap written during lookup merge")

endmodule
`default_nettype wire
